// File: rtl/char_lcd_nibble_interface_core_defines.svh
// Assertion macros used by the checker of the character LCD core.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CLCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("char LCD core check failed");

// Next-cycle implication, checked out of reset.
`define CLCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("char LCD core check failed");

`endif

// File: rtl/clcd_pkg.sv
// Shared types and constants of the character LCD nibble interface core.
// Depends on nothing; every RTL file but clcd_fifo and the defines header imports it.
package clcd_pkg;

  // Opcodes of an input request.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_INSTR = 2'd2;
  localparam logic [1:0] OP_DATA  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RESET_WORD   = 3'd0;
  localparam logic [2:0] CFG_FUNC_WORD    = 3'd1;
  localparam logic [2:0] CFG_OFF_WORD     = 3'd2;
  localparam logic [2:0] CFG_CLEAR_WORD   = 3'd3;
  localparam logic [2:0] CFG_ENTRY_WORD   = 3'd4;
  localparam logic [2:0] CFG_ON_WORD      = 3'd5;
  localparam logic [2:0] CFG_GAP_TICKS    = 3'd6;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 10;
  localparam int CountW    = 17;

  // Request kinds after classification in the front end.
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_INSTR,
    KIND_DATA
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] payload;
  } in_item_t;

  typedef struct packed {
    logic       pin_e;
    logic       pin_rs;
    logic [3:0] pin_data;
    logic       busy_res;
    logic       ready_done;
    logic       rejected;
  } out_item_t;

  // Classified request passed from front end to sequencer.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] payload;
  } cmd_t;

endpackage

// File: rtl/clcd_fifo.sv
// Small register queue used for the command and result queues of the LCD core.
// Depends on nothing but its WIDTH and DEPTH parameters.
module clcd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; only counted entries are read.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/clcd_front.sv
// Front end of the LCD core: accepts input requests and classifies them.
// Depends on clcd_pkg.
module clcd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  clcd_pkg::in_item_t in_item,
  output logic              full,
  output logic              cmd_valid,
  output clcd_pkg::cmd_t    cmd,
  input  logic              cmd_full
);
  import clcd_pkg::*;

  logic      valid_r, valid_nxt;
  cmd_t      cmd_r;
  cmd_kind_t kind;
  logic      take;

  // Map the opcode onto a request kind.
  always_comb begin
    case (in_item.opcode)
      OP_TICK:  kind = KIND_TICK;
      OP_START: kind = KIND_START;
      OP_INSTR: kind = KIND_INSTR;
      OP_DATA:  kind = KIND_DATA;
      default:  kind = KIND_TICK;
    endcase
  end

  // The holding register refills in the cycle it drains.
  assign full      = valid_r && cmd_full;
  assign take      = push && !full;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !cmd_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r.kind    <= kind;
      cmd_r.payload <= in_item.payload;
    end
  end

endmodule

// File: rtl/clcd_back.sv
// Back end of the LCD core: bus sequencer, wait counter and configuration.
// Depends on clcd_pkg; takes one classified request per cycle while step is high.
module clcd_back #(
  parameter int POWER_WAIT_TICKS = 100000,
  parameter int RESET_WAIT_TICKS = 10000,
  parameter int SHORT_WAIT_TICKS = 200,
  parameter int CLEAR_WAIT_TICKS = 4000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  clcd_pkg::cmd_t                     cmd,
  output clcd_pkg::out_item_t                res,
  input  logic                               cfg_we,
  input  logic [clcd_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [clcd_pkg::CfgDataW-1:0]      cfg_data
);
  import clcd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_EHI,
    PH_ELO,
    PH_WAIT
  } phase_t;

  localparam logic [3:0] STEP_NONE  = 4'd0;
  localparam logic [3:0] STEP_POWER = 4'd1;
  localparam logic [3:0] STEP_RST1  = 4'd2;
  localparam logic [3:0] STEP_RST2  = 4'd3;
  localparam logic [3:0] STEP_RST3  = 4'd4;
  localparam logic [3:0] STEP_FNIB  = 4'd5;
  localparam logic [3:0] STEP_FSET  = 4'd6;
  localparam logic [3:0] STEP_OFF   = 4'd7;
  localparam logic [3:0] STEP_CLEAR = 4'd8;
  localparam logic [3:0] STEP_ENTRY = 4'd9;
  localparam logic [3:0] STEP_LAST  = 4'd10;

  // Configuration registers.
  logic [7:0] reset_word_r, func_word_r, off_word_r;
  logic [7:0] clear_word_r, entry_word_r, on_word_r;
  logic [9:0] gap_ticks_r;

  // Sequencer state.
  phase_t            phase_r, phase_nxt;
  logic [3:0]        init_step_r, init_step_nxt;
  logic [CountW-1:0] wait_r, wait_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              low_half_r, low_half_nxt;
  logic              sel_r, sel_nxt;
  logic              strobe_r, strobe_nxt;
  logic              done_r, done_nxt;
  logic              rej;

  logic [3:0]        launch_step;
  logic [7:0]        launch_word;
  logic              launch_full;
  logic [CountW-1:0] wait_after;

  // Byte and form of the next initialization item.
  assign launch_step = init_step_r + 4'd1;
  always_comb begin
    launch_full = 1'b1;
    case (launch_step)
      STEP_RST1, STEP_RST2, STEP_RST3: begin
        launch_word = reset_word_r;
        launch_full = 1'b0;
      end
      STEP_FNIB: begin
        launch_word = func_word_r;
        launch_full = 1'b0;
      end
      STEP_FSET:  launch_word = func_word_r;
      STEP_OFF:   launch_word = off_word_r;
      STEP_CLEAR: launch_word = clear_word_r;
      STEP_ENTRY: launch_word = entry_word_r;
      default:    launch_word = on_word_r;
    endcase
  end

  // Wait length after the item that just finished its strobes.
  always_comb begin
    case (init_step_r)
      STEP_RST1:            wait_after = CountW'(RESET_WAIT_TICKS);
      STEP_RST2, STEP_RST3: wait_after = CountW'(SHORT_WAIT_TICKS);
      STEP_CLEAR:           wait_after = CountW'(CLEAR_WAIT_TICKS);
      default:              wait_after = CountW'(gap_ticks_r);
    endcase
  end

  // Next state for one request.
  always_comb begin
    phase_nxt     = phase_r;
    init_step_nxt = init_step_r;
    wait_nxt      = wait_r;
    held_nxt      = held_r;
    low_half_nxt  = low_half_r;
    sel_nxt       = sel_r;
    strobe_nxt    = strobe_r;
    done_nxt      = done_r;
    rej           = 1'b0;
    if (cmd.kind == KIND_TICK) begin
      case (phase_r)
        PH_EHI: begin
          strobe_nxt = 1'b0;
          phase_nxt  = PH_ELO;
        end
        PH_ELO: begin
          if (low_half_r) begin
            low_half_nxt = 1'b0;
            strobe_nxt   = 1'b1;
            phase_nxt    = PH_EHI;
          end else begin
            wait_nxt  = wait_after;
            phase_nxt = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (wait_r > CountW'(1)) begin
            wait_nxt = wait_r - CountW'(1);
          end else if (init_step_r == STEP_NONE) begin
            phase_nxt = PH_IDLE;
          end else if (init_step_r >= STEP_LAST) begin
            done_nxt      = 1'b1;
            init_step_nxt = STEP_NONE;
            phase_nxt     = PH_IDLE;
          end else begin
            // Launch the next initialization item.
            init_step_nxt = launch_step;
            sel_nxt       = 1'b0;
            held_nxt      = launch_full ? launch_word : {4'd0, launch_word[7:4]};
            low_half_nxt  = launch_full;
            strobe_nxt    = 1'b1;
            phase_nxt     = PH_EHI;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else if (phase_r != PH_IDLE) begin
      rej = 1'b1;
    end else if (cmd.kind == KIND_START) begin
      done_nxt      = 1'b0;
      init_step_nxt = STEP_POWER;
      sel_nxt       = 1'b0;
      strobe_nxt    = 1'b0;
      low_half_nxt  = 1'b0;
      wait_nxt      = CountW'(POWER_WAIT_TICKS);
      phase_nxt     = PH_WAIT;
    end else begin
      sel_nxt      = (cmd.kind == KIND_DATA);
      held_nxt     = cmd.payload;
      low_half_nxt = 1'b1;
      strobe_nxt   = 1'b1;
      phase_nxt    = PH_EHI;
    end
  end

  // Result fields follow the updated state.
  always_comb begin
    res.pin_e      = strobe_nxt;
    res.pin_rs     = sel_nxt;
    res.pin_data   = low_half_nxt ? held_nxt[7:4] : held_nxt[3:0];
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.ready_done = done_nxt;
    res.rejected   = rej;
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      init_step_r <= STEP_NONE;
      wait_r      <= '0;
      held_r      <= '0;
      low_half_r  <= 1'b0;
      sel_r       <= 1'b0;
      strobe_r    <= 1'b0;
      done_r      <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      init_step_r <= init_step_nxt;
      wait_r      <= wait_nxt;
      held_r      <= held_nxt;
      low_half_r  <= low_half_nxt;
      sel_r       <= sel_nxt;
      strobe_r    <= strobe_nxt;
      done_r      <= done_nxt;
    end
  end

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_word_r <= 8'd48;
      func_word_r  <= 8'd40;
      off_word_r   <= 8'd8;
      clear_word_r <= 8'd1;
      entry_word_r <= 8'd6;
      on_word_r    <= 8'd12;
      gap_ticks_r  <= 10'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_WORD: reset_word_r <= cfg_data[7:0];
        CFG_FUNC_WORD:  func_word_r  <= cfg_data[7:0];
        CFG_OFF_WORD:   off_word_r   <= cfg_data[7:0];
        CFG_CLEAR_WORD: clear_word_r <= cfg_data[7:0];
        CFG_ENTRY_WORD: entry_word_r <= cfg_data[7:0];
        CFG_ON_WORD:    on_word_r    <= cfg_data[7:0];
        CFG_GAP_TICKS:  gap_ticks_r  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/char_lcd_nibble_interface_core.sv
// Top level of the 4-bit character LCD interface core.
// Depends on clcd_pkg, clcd_front, clcd_fifo and clcd_back.
//
//   Channel  Handshake        Payload
//   input    push / full      in_item  (opcode, payload)
//   result   empty / pop      out_item (pins, busy, ready, rejected)
//   config   cfg_valid/ready  cfg_index, cfg_data
//
// One request per cycle is accepted while full is low, and one result per cycle is delivered while empty is low.
// A request's result reaches out_item through the front register, which hands it
// to the command queue, then the sequencer, which writes the result queue.
// Reset is synchronous; both queues come out empty, registers at defaults.
// A full result queue stalls the sequencer; the command queue and front
// register absorb requests until full rises.
module char_lcd_nibble_interface_core #(
  parameter int POWER_WAIT_TICKS = 100000,
  parameter int RESET_WAIT_TICKS = 10000,
  parameter int SHORT_WAIT_TICKS = 200,
  parameter int CLEAR_WAIT_TICKS = 4000,
  parameter int QUEUE_DEPTH      = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  clcd_pkg::in_item_t              in_item,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output clcd_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clcd_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [clcd_pkg::CfgDataW-1:0]   cfg_data
);
  import clcd_pkg::*;

  logic      front_valid;
  cmd_t      front_cmd;
  logic      cmd_full, cmd_empty;
  cmd_t      cmd_head;
  logic      res_full;
  out_item_t res;
  logic      step;

  assign cfg_ready = 1'b1;
  assign step      = !cmd_empty && !res_full;

  // Accept and classify requests.
  clcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .cmd_valid(front_valid),
    .cmd      (front_cmd),
    .cmd_full (cmd_full)
  );

  // Queue between front end and sequencer.
  clcd_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (front_valid),
    .wr_data(front_cmd),
    .full   (cmd_full),
    .pop    (step),
    .rd_data(cmd_head),
    .empty  (cmd_empty)
  );

  // Bus sequencer.
  clcd_back #(
    .POWER_WAIT_TICKS(POWER_WAIT_TICKS),
    .RESET_WAIT_TICKS(RESET_WAIT_TICKS),
    .SHORT_WAIT_TICKS(SHORT_WAIT_TICKS),
    .CLEAR_WAIT_TICKS(CLEAR_WAIT_TICKS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .cmd      (cmd_head),
    .res      (res),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Result queue toward the consumer.
  clcd_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (step),
    .wr_data(res),
    .full   (res_full),
    .pop    (pop),
    .rd_data(out_item),
    .empty  (empty)
  );

endmodule

// File: rtl/clcd_checker.sv
// Port-level checks of the character LCD core, bound to its top level.
// Depends on clcd_pkg and char_lcd_nibble_interface_core_defines.svh.
`include "char_lcd_nibble_interface_core_defines.svh"

module clcd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 push,
  input clcd_pkg::in_item_t   in_item,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input clcd_pkg::out_item_t  out_item
);
  import clcd_pkg::*;

  // The result queue comes out of reset empty.
  `CLCD_ASSERT_SAME(a_empty_after_reset, $rose(rst_n), empty)

  // A dropped request only happens while the sequencer is busy.
  `CLCD_ASSERT_SAME(a_reject_busy, !empty && out_item.rejected, out_item.busy_res)

  // The enable strobe is only high inside a running transfer.
  `CLCD_ASSERT_SAME(a_strobe_busy, !empty && out_item.pin_e, out_item.busy_res)

  // A waiting result is not withdrawn before it is taken.
  `CLCD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)

endmodule

bind char_lcd_nibble_interface_core clcd_checker u_clcd_checker (.*);
